/* design/rmse_pkg.sv */
`default_nettype none
package rmse_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 32;
	localparam int FRAC_BITS   = 8;
	localparam int SUM_W       = 48;
	localparam int SQ_W        = 64;
	localparam int OUT_W       = 24;
	localparam int DIVD_W      = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W      = SQ_W / 2;
	localparam int DIV_STEP_W  = $clog2(DIVD_W + 1);
	localparam int ROOT_STEP_W = $clog2(ROOT_W + 1);

	localparam logic [OUT_W-1:0] MEAN_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] MEAN_NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_RESET = 2'd2
	} command_t;

	typedef struct packed {
		command_t                       command;
		logic signed [SAMPLE_BITS-1:0]  sample;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0]  mean_value;
		logic [OUT_W-1:0]         standard_error;
		logic                     freshly_computed;
		logic                     count_saturated;
	} out_t;

	typedef struct packed {
		logic take_item;
		logic load_plain;
		logic mean_start;
		logic e2_start;
		logic e2_latch;
		logic var_start;
		logic sqrt_start;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic count_gt1;
		logic div_done;
		logic sqrt_done;
	} status_t;

endpackage
`default_nettype wire

/* design/running_mean_std_error_top.sv */
`default_nettype none
// Running mean and standard error of the mean over a stream of signed samples.
// Input channel (in_valid/in_ready/in_data): a command and a 16-bit sample.
//   Add counts the sample into the sum and the sum of squares, query
//   recomputes the Q16.8 mean and standard error, reset clears the sums.
// Output channel (out_valid/out_ready/out_data): exactly one result per
//   input transfer, in order: held mean, held error, fresh flag, saturation.
// Add, reset, unused codes and queries on fewer than two samples: the result
//   is in the output register in the cycle after the transfer, and a new item is
//   taken every cycle while results drain (one per cycle sustained).
// A query on two or more samples runs three restoring divisions on one shared
//   divider (mean, mean of squares, variance over n - 1), then a square root.
//   in_ready is low for that whole run.
// A stalled receiver holds the output register; in_ready then stays low
//   until the pending result transfers.
// Reset (arst_n low) clears count, sums and the held mean and error, and
//   empties the output register. Samples past a full count are dropped.
module running_mean_std_error_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rmse_pkg::in_t     in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rmse_pkg::out_t         out_data
);
	import rmse_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: handshakes and the step order of a query
	rmse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (in_data.command),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// accumulators, shared divider, root unit and the output register
	rmse_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.out_data (out_data),
		.status   (status)
	);

endmodule
`default_nettype wire

/* design/rmse_div.sv */
`default_nettype none
module rmse_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [rmse_pkg::DIVD_W-1:0]       dividend,
	input  wire logic [rmse_pkg::COUNT_BITS-1:0]   divisor,
	output logic                                   done,
	output logic [rmse_pkg::DIVD_W-1:0]            quotient
);
	import rmse_pkg::*;

	logic [DIVD_W-1:0]     dq_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dq_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == DIV_STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DIV_STEP_W'(DIVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == DIV_STEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule
`default_nettype wire

/* design/rmse_sqrt.sv */
`default_nettype none
module rmse_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rmse_pkg::SQ_W-1:0]    radicand,
	output logic                              done,
	output logic [rmse_pkg::ROOT_W-1:0]       root
);
	import rmse_pkg::*;

	logic [SQ_W-1:0]        v_q;
	logic [ROOT_W+2:0]      rem_q;
	logic [ROOT_W-1:0]      root_q;
	logic [ROOT_STEP_W-1:0] step_q;
	logic                   busy_q;
	logic                   done_q;
	logic [ROOT_W+2:0]      rem_sh;
	logic [ROOT_W+2:0]      trial;
	logic                   ge;

	// digit-by-digit floor root, two radicand bits per cycle
	assign rem_sh = {rem_q[ROOT_W:0], v_q[SQ_W-1:SQ_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == ROOT_STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= ROOT_STEP_W'(ROOT_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == ROOT_STEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[SQ_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

/* design/rmse_dp.sv */
`default_nettype none
module rmse_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rmse_pkg::in_t      in_data,
	input  wire rmse_pkg::cmd_t     cmd,
	output rmse_pkg::out_t          out_data,
	output rmse_pkg::status_t       status
);
	import rmse_pkg::*;

	logic [COUNT_BITS-1:0]      count_q;
	logic [SUM_W-1:0]           sum_q;
	logic [SQ_W-1:0]            sq_q;
	logic [OUT_W-1:0]           held_mean_q;
	logic [OUT_W-1:0]           held_err_q;
	logic [OUT_W-1:0]           mean_mag_q;
	logic [2*OUT_W-1:0]         m2_q;
	logic [SQ_W-1:0]            e2_q;
	out_t                       out_q;

	logic [COUNT_BITS-1:0]      count_next;
	logic                       count_full;
	logic signed [2*SAMPLE_BITS-1:0] sample_sq;
	logic                       neg;
	logic [SUM_W-1:0]           mag;
	logic [OUT_W-1:0]           mean_mag;
	logic [SQ_W-1:0]            var_val;
	logic [OUT_W-1:0]           err_sat;

	logic                       div_start;
	logic [DIVD_W-1:0]          div_dividend;
	logic [COUNT_BITS-1:0]      div_divisor;
	logic                       div_done;
	logic [DIVD_W-1:0]          quot;
	logic                       sqrt_done;
	logic [ROOT_W-1:0]          root;

	assign count_full = &count_q;
	assign sample_sq  = in_data.sample * in_data.sample;

	always_comb begin
		case (in_data.command)
			CMD_ADD:   count_next = count_full ? count_q : count_q + 1'b1;
			CMD_RESET: count_next = '0;
			default:   count_next = count_q;
		endcase
	end

	// mean magnitude from the first quotient, saturated per sign
	assign neg = sum_q[SUM_W-1];
	assign mag = neg ? (~sum_q + 1'b1) : sum_q;

	always_comb begin
		if (neg)
			mean_mag = (quot > DIVD_W'(MEAN_NEG_MAX)) ? MEAN_NEG_MAX : quot[OUT_W-1:0];
		else
			mean_mag = (quot > DIVD_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX : quot[OUT_W-1:0];
	end

	assign var_val = (e2_q > SQ_W'(m2_q)) ? e2_q - SQ_W'(m2_q) : '0;
	assign err_sat = (root[ROOT_W-1:OUT_W] != '0) ? '1 : root[OUT_W-1:0];

	assign div_start = cmd.mean_start || cmd.e2_start || cmd.var_start;

	always_comb begin
		if (cmd.mean_start)
			div_dividend = DIVD_W'(mag) << FRAC_BITS;
		else if (cmd.e2_start)
			div_dividend = DIVD_W'(sq_q) << (2 * FRAC_BITS);
		else
			div_dividend = DIVD_W'(var_val);
	end

	assign div_divisor = cmd.var_start ? count_q - 1'b1 : count_q;

	rmse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quot)
	);

	rmse_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (quot[SQ_W-1:0]),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			held_mean_q <= '0;
			held_err_q  <= '0;
		end else begin
			if (cmd.take_item) begin
				count_q <= count_next;
				case (in_data.command)
					CMD_ADD: begin
						if (!count_full) begin
							sum_q <= sum_q + SUM_W'(in_data.sample);
							sq_q  <= sq_q + SQ_W'($unsigned(sample_sq));
						end
					end
					CMD_RESET: begin
						sum_q <= '0;
						sq_q  <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.e2_start)
				held_mean_q <= neg ? (~mean_mag + 1'b1) : mean_mag;
			if (cmd.finish)
				held_err_q <= err_sat;
		end
	end

	always_ff @(posedge clk) begin
		m2_q <= mean_mag_q * mean_mag_q;
		if (cmd.e2_start)
			mean_mag_q <= mean_mag;
		if (cmd.e2_latch)
			e2_q <= (quot[DIVD_W-1:SQ_W] != '0) ? '1 : quot[SQ_W-1:0];
		if (cmd.load_plain) begin
			out_q.mean_value       <= held_mean_q;
			out_q.standard_error   <= held_err_q;
			out_q.freshly_computed <= 1'b0;
			out_q.count_saturated  <= &count_next;
		end else if (cmd.finish) begin
			out_q.mean_value       <= held_mean_q;
			out_q.standard_error   <= err_sat;
			out_q.freshly_computed <= 1'b1;
			out_q.count_saturated  <= count_full;
		end
	end

	assign out_data         = out_q;
	assign status.count_gt1 = count_q > COUNT_BITS'(1);
	assign status.div_done  = div_done;
	assign status.sqrt_done = sqrt_done;

endmodule
`default_nettype wire

/* design/rmse_ctrl.sv */
`default_nettype none
module rmse_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire rmse_pkg::command_t   command,
	input  wire logic                 out_ready,
	input  wire rmse_pkg::status_t    status,
	output logic                      in_ready,
	output logic                      out_valid,
	output rmse_pkg::cmd_t            cmd
);
	import rmse_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MEAN = 6'b000010,
		ST_E2   = 6'b000100,
		ST_VAR  = 6'b001000,
		ST_QUOT = 6'b010000,
		ST_ROOT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   xfer;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign xfer     = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take_item  = xfer;
				cmd.mean_start = xfer && (command == CMD_QUERY) && status.count_gt1;
				cmd.load_plain = xfer && !cmd.mean_start;
				if (cmd.mean_start)
					state_next = ST_MEAN;
			end
			ST_MEAN: begin
				if (status.div_done) begin
					cmd.e2_start = 1'b1;
					state_next   = ST_E2;
				end
			end
			ST_E2: begin
				if (status.div_done) begin
					cmd.e2_latch = 1'b1;
					state_next   = ST_VAR;
				end
			end
			ST_VAR: begin
				cmd.var_start = 1'b1;
				state_next    = ST_QUOT;
			end
			ST_QUOT: begin
				if (status.div_done) begin
					cmd.sqrt_start = 1'b1;
					state_next     = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (status.sqrt_done) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_plain || cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* sim/running_mean_std_error_top_tb.sv */
`timescale 1ns / 1ps
module running_mean_std_error_top_tb;
	import rmse_pkg::*;

	// Command 3 has no meaning to the block: it must report the held values.
	localparam command_t CMD_UNUSED = command_t'(2'd3);
	localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

	// Stimulus shape
	localparam int RANDOM_ITEMS  = 600;
	localparam int HOLD_TRIGGER  = 150;  // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES   = 400;
	// A query on two or more samples keeps in_ready low while it runs;
	// wait a bit longer than such a query after the last result for stray outputs.
	localparam int DRAIN_CYCLES  = 320;
	// Watchdog limit on a quiet stretch, well above the long hold-off plus a full query.
	localparam int QUIET_LIMIT   = 4000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	always #10 clk = ~clk;

	running_mean_std_error_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the accumulator state, kept in step with every input
	// transfer. Cleared once at time zero along with the block.
	// ------------------------------------------------------------------
	logic [COUNT_BITS-1:0] n_samples = '0;
	logic [SUM_W-1:0]      sum_acc   = '0;
	logic [SQ_W-1:0]       sq_acc    = '0;
	logic [OUT_W-1:0]      mean_held = '0;
	logic [OUT_W-1:0]      err_held  = '0;

	in_t  pending_items[$];     // filled by the initial block, drained by the driver
	out_t expected_results[$];  // one entry per input transfer, oldest first

	int total_items    = 0;
	int results_seen   = 0;
	int mismatches     = 0;
	int adds_taken     = 0;
	int fresh_queries  = 0;
	int held_queries   = 0;
	int clears_taken   = 0;
	int unused_taken   = 0;
	int peak_count     = 0;
	int longest_hold   = 0;

	// Integer square root, floor; built up one result bit at a time.
	function automatic logic [31:0] floor_root(logic [63:0] v);
		logic [31:0] root;
		logic [31:0] cand;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = root | (32'd1 << b);
			if (64'(cand) * 64'(cand) <= v)
				root = cand;
		end
		return root;
	endfunction

	// Applies one command to the shadow state and returns the result the
	// block should produce for it.
	function automatic out_t apply_command(in_t item);
		out_t                   res;
		logic                   fresh;
		logic signed [SAMPLE_BITS:0] s_ext;
		logic [SAMPLE_BITS:0]   mag_s;
		logic                   neg;
		logic [SUM_W-1:0]       sum_mag;
		logic [63:0]            mean_quot;
		logic [63:0]            mean_mag;
		logic [63:0]            e2;
		logic [63:0]            m2;
		logic [63:0]            spread;
		logic [DIVD_W-1:0]      sq_scaled;
		logic [31:0]            root;
		fresh = 1'b0;
		case (item.command)
			CMD_ADD: begin
				// Full counter: the sample is dropped.
				if (n_samples != COUNT_FULL) begin
					s_ext = item.sample;
					mag_s = s_ext[SAMPLE_BITS] ? -s_ext : s_ext;
					n_samples = n_samples + 1'b1;
					sum_acc = sum_acc + SUM_W'(s_ext);
					sq_acc = sq_acc + SQ_W'(mag_s) * SQ_W'(mag_s);
					adds_taken++;
					if (n_samples > peak_count)
						peak_count = n_samples;
				end
			end
			CMD_QUERY: begin
				if (n_samples > 1) begin
					// Mean: magnitude divide, truncation toward zero, then saturate.
					neg = sum_acc[SUM_W-1];
					sum_mag = neg ? -sum_acc : sum_acc;
					mean_quot = (64'(sum_mag) << FRAC_BITS) / 64'(n_samples);
					if (neg) begin
						mean_mag = (mean_quot > 64'(MEAN_NEG_MAX)) ? 64'(MEAN_NEG_MAX) : mean_quot;
						mean_held = -mean_mag[OUT_W-1:0];
					end else begin
						mean_mag = (mean_quot > 64'(MEAN_POS_MAX)) ? 64'(MEAN_POS_MAX) : mean_quot;
						mean_held = mean_mag[OUT_W-1:0];
					end
					// Mean of squares in Q.2F, saturated to 64 bits.
					sq_scaled = DIVD_W'(sq_acc) << (2 * FRAC_BITS);
					sq_scaled = sq_scaled / DIVD_W'(n_samples);
					e2 = (sq_scaled > DIVD_W'({SQ_W{1'b1}})) ? {64{1'b1}} : sq_scaled[63:0];
					m2 = mean_mag * mean_mag;
					spread = (e2 > m2) ? e2 - m2 : 64'd0;
					root = floor_root(spread / (64'(n_samples) - 64'd1));
					err_held = (root > 32'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : root[OUT_W-1:0];
					fresh = 1'b1;
					fresh_queries++;
				end else begin
					held_queries++;
				end
			end
			CMD_RESET: begin
				// Held mean and error survive a clear.
				n_samples = '0;
				sum_acc = '0;
				sq_acc = '0;
				clears_taken++;
			end
			default: begin
				unused_taken++;
			end
		endcase
		res.mean_value = mean_held;
		res.standard_error = err_held;
		res.freshly_computed = fresh;
		res.count_saturated = (n_samples == COUNT_FULL);
		return res;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	task automatic check_result(out_t got);
		out_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing pending: %h", got));
			return;
		end
		want = expected_results.pop_front();
		if (got.mean_value !== want.mean_value)
			report_mismatch($sformatf("result %0d mean_value %h, want %h",
				results_seen, got.mean_value, want.mean_value));
		if (got.standard_error !== want.standard_error)
			report_mismatch($sformatf("result %0d standard_error %h, want %h",
				results_seen, got.standard_error, want.standard_error));
		if (got.freshly_computed !== want.freshly_computed)
			report_mismatch($sformatf("result %0d freshly_computed %b, want %b",
				results_seen, got.freshly_computed, want.freshly_computed));
		if (got.count_saturated !== want.count_saturated)
			report_mismatch($sformatf("result %0d count_saturated %b, want %b",
				results_seen, got.count_saturated, want.count_saturated));
		results_seen++;
	endtask

	function automatic void queue_item(command_t c, logic [SAMPLE_BITS-1:0] s);
		in_t it;
		it.command = c;
		it.sample = s;
		pending_items.push_back(it);
	endfunction

	// Sample flavors for a run of adds: full range, small around zero,
	// range extremes, clustered near one value, large positive.
	function automatic logic [SAMPLE_BITS-1:0] pick_sample(int style,
			logic [SAMPLE_BITS-1:0] base);
		case (style)
			0: return SAMPLE_BITS'($urandom_range(0, 65535));
			1: return SAMPLE_BITS'($urandom_range(0, 16)) - SAMPLE_BITS'(8);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h8001;
					default: return 16'h0000;
				endcase
			end
			3: return base + SAMPLE_BITS'($urandom_range(0, 3));
			default: return SAMPLE_BITS'($urandom_range(24000, 32767));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge. in_fire tells the
	// driver at the following falling edge that its item was taken.
	// ------------------------------------------------------------------
	logic in_fire = 1'b0;
	int   quiet_cycles = 0;

	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_command(in_data));
			if (out_valid && out_ready)
				check_result(out_data);
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: stuck for %0d cycles, %0d results still pending",
				quiet_cycles, expected_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver: bursts of back-to-back items with random gaps in between.
	// An offered item is held until the transfer happens.
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// still waiting for the transfer
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_items.size() > 0) begin
			in_data <= pending_items.pop_front();
			in_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				// about a third of bursts run straight into the next one
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall rate changes in phases (including stretches with no
	// stall at all). Once, well into the run, it holds off for a long
	// stretch while the driver keeps offering, so the block backs up.
	// ------------------------------------------------------------------
	int  stall_pct  = 0;
	int  phase_left = 0;
	int  hold_left  = 0;
	logic hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
			longest_hold <= HOLD_CYCLES;
		end else begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct <= 0;
					1: stall_pct <= 20;
					2: stall_pct <= 50;
					default: stall_pct <= 85;
				endcase
				phase_left <= $urandom_range(20, 120);
			end else begin
				phase_left <= phase_left - 1;
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int kind;
		int n_add;
		int style;
		logic [SAMPLE_BITS-1:0] base;
		int directed_items;

		// Directed part: queries on zero and one sample, range extremes,
		// unused command code, query after a clear (held values kept),
		// zero spread, mean at the negative limit.
		queue_item(CMD_QUERY,  16'h0000);
		queue_item(CMD_ADD,    16'h7FFF);
		queue_item(CMD_QUERY,  16'hFFFF);
		queue_item(CMD_ADD,    16'h8000);
		queue_item(CMD_QUERY,  16'h0000);
		queue_item(CMD_UNUSED, 16'h5A5A);
		queue_item(CMD_ADD,    16'h0000);
		queue_item(CMD_ADD,    16'hFFFF);
		queue_item(CMD_QUERY,  16'h0000);
		queue_item(CMD_RESET,  16'hFFFF);
		queue_item(CMD_QUERY,  16'h0000);
		queue_item(CMD_ADD,    16'd1234);
		queue_item(CMD_ADD,    16'd1234);
		queue_item(CMD_ADD,    16'd1234);
		queue_item(CMD_QUERY,  16'h0000);
		queue_item(CMD_RESET,  16'h0000);
		queue_item(CMD_ADD,    16'h8000);
		queue_item(CMD_ADD,    16'h8000);
		queue_item(CMD_QUERY,  16'h0000);
		queue_item(CMD_RESET,  16'hA5A5);
		queue_item(CMD_ADD,    16'h7FFF);
		queue_item(CMD_ADD,    16'h7FFF);
		queue_item(CMD_ADD,    16'h8000);
		queue_item(CMD_QUERY,  16'h0000);
		queue_item(CMD_UNUSED, 16'hA5A5);
		directed_items = pending_items.size();

		// Random part: mostly runs of adds closed by a query, some with a
		// clear first; the rest are stray commands and queries on too few
		// samples.
		while (pending_items.size() < directed_items + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 78) begin
				if ($urandom_range(0, 1) == 1)
					queue_item(CMD_RESET, SAMPLE_BITS'($urandom()));
				n_add = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(2, 12);
				style = $urandom_range(0, 4);
				base = SAMPLE_BITS'($urandom());
				for (int i = 0; i < n_add; i++) begin
					queue_item(CMD_ADD, pick_sample(style, base));
					if ($urandom_range(0, 19) == 0)
						queue_item(CMD_QUERY, SAMPLE_BITS'($urandom()));
				end
				queue_item(CMD_QUERY, SAMPLE_BITS'($urandom()));
			end else if (kind < 90) begin
				repeat ($urandom_range(1, 4))
					queue_item(command_t'(2'($urandom_range(0, 3))), SAMPLE_BITS'($urandom()));
			end else begin
				queue_item(CMD_RESET, SAMPLE_BITS'($urandom()));
				if ($urandom_range(0, 1) == 1)
					queue_item(CMD_ADD, SAMPLE_BITS'($urandom()));
				queue_item(CMD_QUERY, SAMPLE_BITS'($urandom()));
			end
		end
		total_items = pending_items.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// One result per transfer: done once every item has its result.
		wait (results_seen == total_items);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d items checked: %0d adds, %0d fresh queries, %0d held queries",
			results_seen, adds_taken, fresh_queries, held_queries);
		$display("tb: %0d clears, %0d unused codes, peak count %0d, receiver hold-off %0d cycles",
			clears_taken, unused_taken, peak_count, longest_hold);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
